### hw/rtl/vrrdo_pkg.sv
// Shared types and constants for the variable-length record ring.
// No dependencies; imported by the ring top level.
package vrrdo_pkg;

  // Field widths fixed by the word format.
  localparam int DATA_W           = 64;
  localparam int REC_LEN_W        = 7;
  localparam int LEN_W            = 8;
  localparam int CFG_W            = 9;
  localparam int HELD_W           = 8;
  localparam int PCT_W            = 7;
  localparam int DROP_W           = 8;

  // Shortest legal record, smallest usable capacity, percent scale.
  localparam int MIN_RECORD_WORDS = 2;
  localparam int MIN_CAPACITY     = 8;
  localparam int PCT_SCALE        = 100;

  // Quotient bits produced by the fullness divider (two per cycle).
  localparam int Q_W              = 8;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSH_OK  = 2'd0,
    ST_WORD_OUT = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_REJECT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ROOM,
    S_FREE_RD,
    S_FREE_A,
    S_FREE_B,
    S_WRITE,
    S_FULL,
    S_DIV,
    S_EMIT,
    S_STREAM
  } state_t;

  typedef struct packed {
    op_t                    operation;
    logic                   first_word;
    logic [REC_LEN_W-1:0]   record_words;
    logic [DATA_W-1:0]      push_data;
  } in_t;

  typedef struct packed {
    status_t                status;
    logic [DATA_W-1:0]      pop_data;
    logic                   last_of_record;
    logic [HELD_W-1:0]      records_held;
    logic [PCT_W-1:0]       fullness_percent;
    logic [DROP_W-1:0]      dropped_records;
  } out_t;

endpackage

### hw/rtl/vrrdo_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vrrdo_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the entry being written returns old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/variable_record_ring_drop_oldest.sv
// Ring store of variable-length records with eviction of the oldest records.
// Depends on vrrdo_pkg (types, codes) and vrrdo_ram (word and length stores).
//
//   channel   ports                               direction  handshake
//   input     start, busy, in_word                in         start & !busy
//   result    out_strobe, out_word                out        out_strobe, one cycle
//   config    cfg_wr_en, cfg_wr_data              in         cfg_wr_en
//
// A stored non-first push word passes through decode, store write, fullness
// setup, the divider steps and the result; a rejected word or a pop of an
// empty ring skips the store write. A first word adds a room check, a wrap to
// word 0 if needed and a length-store read and next-length check per eviction.
// A pop frees its record, then streams one word a cycle from the word store.
// Synchronous active-low reset empties the ring; results cannot be stalled.
module variable_record_ring_drop_oldest
  import vrrdo_pkg::*;
#(
  parameter int STORE_WORDS      = 256,
  parameter int MAX_RECORD_WORDS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_word,
  output logic             out_strobe,
  output out_t             out_word,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int AW      = $clog2(STORE_WORDS);
  localparam int CAPW    = $clog2(STORE_WORDS + 1);
  localparam int IW      = (AW > LEN_W) ? AW + 1 : LEN_W + 1;
  localparam int CMPW    = (CAPW > CFG_W) ? CAPW : CFG_W;
  localparam int CNTW    = $clog2(STORE_WORDS / 2 + 1);
  localparam int DW      = CAPW + Q_W - 1;
  localparam int CAP_RST = (STORE_WORDS < 256) ? STORE_WORDS : 256;

  state_t               state_r, state_nxt;
  in_t                  item_r, item_nxt;
  status_t              status_r, status_nxt;
  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]        wr_idx_r, wr_idx_nxt;
  logic [CNTW-1:0]      count_r, count_nxt;
  logic [CNTW-1:0]      drop_r, drop_nxt;
  logic [REC_LEN_W-1:0] left_r, left_nxt;
  logic [REC_LEN_W-1:0] open_r, open_nxt;
  logic [CAPW-1:0]      cap_r, cap_nxt;
  logic [AW-1:0]        pop_base_r, pop_base_nxt;
  logic [REC_LEN_W-1:0] pop_len_r, pop_len_nxt;
  logic [REC_LEN_W-1:0] k_r, k_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  logic [DW-1:0]        dvs_r, dvs_nxt;
  logic [Q_W-1:0]       q_r, q_nxt;
  logic [1:0]           step_r, step_nxt;
  logic                 strobe_r, strobe_nxt;
  logic                 pop_sel_r, pop_sel_nxt;
  logic                 last_r, last_nxt;

  // Memory ports.
  logic                 word_we;
  logic [AW-1:0]        word_waddr;
  logic [AW-1:0]        word_raddr;
  logic [DATA_W-1:0]    word_rd;
  logic                 len_we;
  logic [AW-1:0]        len_waddr;
  logic [LEN_W-1:0]     len_wdata;
  logic [AW-1:0]        len_raddr;
  logic [LEN_W-1:0]     len_rd;

  // Shared datapath terms.
  logic                 accept;
  logic [CMPW-1:0]      cfg_ext;
  logic [CAPW-1:0]      cap_cfg;
  logic [IW-1:0]        cap_iw;
  logic [LEN_W-1:0]     len1;
  logic [IW-1:0]        rd_adv;
  logic [CNTW-1:0]      count_dec;
  logic [REC_LEN_W-1:0] rw;
  logic                 bad_len;
  logic [IW-1:0]        wr_plus_len;
  logic                 fit_hi;
  logic                 fit_lo;
  logic [IW-1:0]        wr_end;
  logic [AW-1:0]        push_pos;
  logic [CAPW-1:0]      occ_raw;
  logic [CAPW-1:0]      occ;
  logic                 b1, b0;
  logic [DW-1:0]        rem_a, rem_b;
  logic                 stream_last;
  state_t               after_free;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Word store and length side store.
  vrrdo_ram #(.WIDTH(DATA_W), .DEPTH(STORE_WORDS)) u_word_ram (
    .clk     (clk),
    .wr_en   (word_we),
    .wr_addr (word_waddr),
    .wr_data (item_r.push_data),
    .rd_addr (word_raddr),
    .rd_data (word_rd)
  );

  vrrdo_ram #(.WIDTH(LEN_W), .DEPTH(STORE_WORDS)) u_len_ram (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (len_waddr),
    .wr_data (len_wdata),
    .rd_addr (len_raddr),
    .rd_data (len_rd)
  );

  // Capacity write is clamped to the usable range.
  assign cfg_ext = CMPW'(cfg_wr_data);
  assign cap_cfg = (cfg_ext < CMPW'(MIN_CAPACITY)) ? CAPW'(MIN_CAPACITY) :
                   (cfg_ext > CMPW'(STORE_WORDS))  ? CAPW'(STORE_WORDS)  :
                   CAPW'(cfg_ext);
  assign cap_iw  = IW'(cap_r);

  // Freeing the oldest record: a filler length counts as one word.
  assign len1      = (len_rd == '0) ? LEN_W'(1) : len_rd;
  assign rd_adv    = IW'(rd_idx_r) + IW'(len1);
  assign count_dec = count_r - CNTW'(1);

  // Length checks and room checks for a new record.
  assign rw          = item_r.record_words;
  assign bad_len     = (rw < REC_LEN_W'(MIN_RECORD_WORDS)) ||
                       (rw > REC_LEN_W'(MAX_RECORD_WORDS)) || (IW'(rw) > cap_iw);
  assign wr_plus_len = IW'(wr_idx_r) + IW'(rw);
  assign fit_hi      = (wr_plus_len <= cap_iw);
  assign fit_lo      = (wr_plus_len <= IW'(rd_idx_r));

  // Position of the current push word and end of the finished record.
  assign wr_end   = IW'(wr_idx_r) + IW'(open_r);
  assign push_pos = AW'(IW'(wr_idx_r) + IW'(open_r - left_r));

  // Occupied words, filler included.
  assign occ_raw = (wr_idx_r > rd_idx_r) ? CAPW'(wr_idx_r) - CAPW'(rd_idx_r) :
                   cap_r - (CAPW'(rd_idx_r) - CAPW'(wr_idx_r));
  assign occ     = (count_r == '0) ? '0 : ((occ_raw > cap_r) ? cap_r : occ_raw);

  // Two restoring divider steps per cycle.
  assign b1    = (rem_r >= dvs_r);
  assign rem_a = b1 ? rem_r - dvs_r : rem_r;
  assign b0    = (rem_a >= (dvs_r >> 1));
  assign rem_b = b0 ? rem_a - (dvs_r >> 1) : rem_a;

  // Streaming read address and last-word flag.
  assign word_raddr  = AW'(IW'(pop_base_r) + IW'(k_r));
  assign stream_last = ((k_r + REC_LEN_W'(1)) == pop_len_r);

  assign after_free = (item_r.operation == OP_POP) ? S_FULL : S_ROOM;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (item_r.operation == OP_POP) begin
          state_nxt = (count_r == '0) ? S_FULL : S_FREE_RD;
        end else if (item_r.first_word) begin
          state_nxt = bad_len ? S_FULL : S_ROOM;
        end else begin
          state_nxt = (left_r == '0) ? S_FULL : S_WRITE;
        end
      end
      S_ROOM: begin
        if (count_r == '0) begin
          state_nxt = S_WRITE;
        end else if (wr_idx_r > rd_idx_r) begin
          state_nxt = fit_hi ? S_WRITE : S_ROOM;
        end else begin
          state_nxt = fit_lo ? S_WRITE : S_FREE_RD;
        end
      end
      S_FREE_RD: state_nxt = S_FREE_A;
      S_FREE_A: begin
        if (count_dec == '0 || rd_adv >= cap_iw) state_nxt = after_free;
        else state_nxt = S_FREE_B;
      end
      S_FREE_B: state_nxt = after_free;
      S_WRITE:  state_nxt = S_FULL;
      S_FULL:   state_nxt = S_DIV;
      S_DIV: begin
        if (step_r == 2'd3) begin
          state_nxt = (status_r == ST_WORD_OUT) ? S_STREAM : S_EMIT;
        end
      end
      S_EMIT: state_nxt = S_IDLE;
      S_STREAM: begin
        if (stream_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result strobe.
  always_comb begin
    item_nxt     = item_r;
    status_nxt   = status_r;
    rd_idx_nxt   = rd_idx_r;
    wr_idx_nxt   = wr_idx_r;
    count_nxt    = count_r;
    drop_nxt     = drop_r;
    left_nxt     = left_r;
    open_nxt     = open_r;
    cap_nxt      = cap_r;
    pop_base_nxt = pop_base_r;
    pop_len_nxt  = pop_len_r;
    k_nxt        = k_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    q_nxt        = q_r;
    step_nxt     = step_r;
    strobe_nxt   = 1'b0;
    pop_sel_nxt  = 1'b0;
    last_nxt     = 1'b0;
    word_we      = 1'b0;
    word_waddr   = push_pos;
    len_we       = 1'b0;
    len_waddr    = wr_idx_r;
    len_wdata    = '0;
    len_raddr    = rd_idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_word;
          drop_nxt = '0;
        end
      end
      S_DECODE: begin
        if (item_r.operation == OP_POP) begin
          status_nxt = (count_r == '0) ? ST_EMPTY : ST_WORD_OUT;
        end else if (item_r.first_word) begin
          status_nxt = bad_len ? ST_REJECT : ST_PUSH_OK;
          left_nxt   = bad_len ? '0 : rw;
          open_nxt   = bad_len ? '0 : rw;
        end else begin
          status_nxt = (left_r == '0) ? ST_REJECT : ST_PUSH_OK;
        end
      end
      S_ROOM: begin
        if (count_r == '0) begin
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
        end else if (wr_idx_r > rd_idx_r) begin
          // The tail past the write point becomes a skipped filler.
          if (!fit_hi) begin
            len_we     = 1'b1;
            wr_idx_nxt = '0;
          end
        end else if (!fit_lo) begin
          drop_nxt = drop_r + CNTW'(1);
        end
      end
      S_FREE_A: begin
        if (item_r.operation == OP_POP) begin
          pop_base_nxt = rd_idx_r;
          pop_len_nxt  = (len1 > LEN_W'(MAX_RECORD_WORDS)) ?
                         REC_LEN_W'(MAX_RECORD_WORDS) : REC_LEN_W'(len1);
        end
        count_nxt = count_dec;
        len_raddr = AW'(rd_adv);
        if (count_dec == '0) begin
          rd_idx_nxt = wr_idx_r;
        end else if (rd_adv >= cap_iw) begin
          rd_idx_nxt = '0;
        end else begin
          rd_idx_nxt = AW'(rd_adv);
        end
      end
      S_FREE_B: begin
        // A filler at the new read point means the next record sits at word 0.
        if (len_rd == '0) rd_idx_nxt = '0;
      end
      S_WRITE: begin
        word_we  = 1'b1;
        left_nxt = left_r - REC_LEN_W'(1);
        if (left_r == REC_LEN_W'(1)) begin
          len_we     = 1'b1;
          len_wdata  = LEN_W'(open_r);
          wr_idx_nxt = (wr_end >= cap_iw) ? '0 : AW'(wr_end);
          count_nxt  = count_r + CNTW'(1);
          open_nxt   = '0;
        end
      end
      S_FULL: begin
        rem_nxt  = DW'(occ) * DW'(PCT_SCALE);
        dvs_nxt  = DW'(cap_r) << (Q_W - 1);
        q_nxt    = '0;
        step_nxt = '0;
        k_nxt    = '0;
      end
      S_DIV: begin
        rem_nxt  = rem_b;
        dvs_nxt  = dvs_r >> 2;
        q_nxt    = {q_r[Q_W-3:0], b1, b0};
        step_nxt = step_r + 2'd1;
      end
      S_EMIT: begin
        strobe_nxt = 1'b1;
      end
      S_STREAM: begin
        strobe_nxt  = 1'b1;
        pop_sel_nxt = 1'b1;
        last_nxt    = stream_last;
        k_nxt       = k_r + REC_LEN_W'(1);
      end
      default: begin
      end
    endcase
    // A capacity write empties the ring and abandons any open record.
    if (cfg_wr_en) begin
      cap_nxt    = cap_cfg;
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      count_nxt  = '0;
      left_nxt   = '0;
      open_nxt   = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_idx_r  <= '0;
      wr_idx_r  <= '0;
      count_r   <= '0;
      left_r    <= '0;
      open_r    <= '0;
      cap_r     <= CAPW'(CAP_RST);
      strobe_r  <= 1'b0;
      pop_sel_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      wr_idx_r  <= wr_idx_nxt;
      count_r   <= count_nxt;
      left_r    <= left_nxt;
      open_r    <= open_nxt;
      cap_r     <= cap_nxt;
      strobe_r  <= strobe_nxt;
      pop_sel_r <= pop_sel_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    drop_r     <= drop_nxt;
    pop_base_r <= pop_base_nxt;
    pop_len_r  <= pop_len_nxt;
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    q_r        <= q_nxt;
    step_r     <= step_nxt;
    last_r     <= last_nxt;
  end

  // Result word; popped data comes straight from the word store's read register.
  assign out_strobe = strobe_r;
  always_comb begin
    out_word.status           = status_r;
    out_word.pop_data         = pop_sel_r ? word_rd : '0;
    out_word.last_of_record   = last_r;
    out_word.records_held     = HELD_W'(count_r);
    out_word.fullness_percent = PCT_W'(q_r);
    out_word.dropped_records  = DROP_W'(drop_r);
  end

  // Both ring pointers stay inside the capacity in use.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CAPW'(rd_idx_r) < cap_r) && (CAPW'(wr_idx_r) < cap_r))
    else $error("ring pointer outside capacity");

  // An accepted word always starts work in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not start work");

  // A result only follows a cycle of work.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without preceding work");

  // Words still owed never exceed the open record's length.
  a_left_le_open: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= open_r)
    else $error("push word count exceeds open record length");

  // Fullness never exceeds one hundred percent.
  a_pct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.fullness_percent <= PCT_W'(PCT_SCALE)))
    else $error("fullness above one hundred percent");

endmodule

### test/tb_variable_record_ring_drop_oldest.sv
// Self-checking testbench for the variable-length record ring with eviction.
// Depends on vrrdo_pkg and the variable_record_ring_drop_oldest top level only.
// A scripted opening is followed by random record traffic at several capacities.
`timescale 1ns / 1ps

module tb_variable_record_ring_drop_oldest;
  import vrrdo_pkg::*;

  localparam int RING_DEPTH     = 256;
  localparam int MAX_REC        = 64;
  localparam int SCRIPT_ROWS    = 23;
  localparam int QUIET_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct packed {
    in_t  word;
    logic typed;
    out_t want;
  } step_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_word;
  logic             out_strobe;
  out_t             out_word;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  // Shadow copy of the ring, updated when a word is accepted.
  bit [63:0]   ring_words   [RING_DEPTH];
  bit [7:0]    ring_lengths [RING_DEPTH];
  int unsigned rd_ptr     = 0;
  int unsigned wr_ptr     = 0;
  int unsigned held_count = 0;
  int unsigned words_due  = 0;
  int unsigned open_len   = 0;
  int unsigned cap_reg    = 256;

  out_t        step_results [$];
  out_t        results_due  [$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;

  variable_record_ring_drop_oldest #(
    .STORE_WORDS      (RING_DEPTH),
    .MAX_RECORD_WORDS (MAX_REC)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_strobe  (out_strobe),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_t cmd(op_t op, logic first, logic [6:0] len, logic [63:0] data);
    in_t w;
    w.operation    = op;
    w.first_word   = first;
    w.record_words = len;
    w.push_data    = data;
    return w;
  endfunction

  function automatic out_t reply(status_t st, int unsigned held, int unsigned pct);
    out_t r;
    r                  = '0;
    r.status           = st;
    r.records_held     = held[7:0];
    r.fullness_percent = pct[6:0];
    return r;
  endfunction

  function automatic int unsigned eff_capacity();
    if (cap_reg < MIN_CAPACITY) return MIN_CAPACITY;
    if (cap_reg > RING_DEPTH) return RING_DEPTH;
    return cap_reg;
  endfunction

  // Frees the oldest record and skips a filler that may follow it.
  function automatic void release_oldest(input int unsigned cap);
    int unsigned len;
    len = 32'(ring_lengths[rd_ptr % RING_DEPTH]);
    if (len == 0) len = 1;
    rd_ptr += len;
    if (held_count > 0) held_count--;
    if (held_count == 0) rd_ptr = wr_ptr;
    else if (rd_ptr >= cap) rd_ptr = 0;
    else if (ring_lengths[rd_ptr % RING_DEPTH] == 0) rd_ptr = 0;
  endfunction

  // Works out the results of one accepted word into step_results.
  function automatic void ring_predict(input in_t w);
    int unsigned cap, len, k, dropped, occ, pct;
    status_t     st;
    out_t        r;
    bit          fits;
    cap     = eff_capacity();
    st      = ST_PUSH_OK;
    dropped = 0;
    r       = '0;
    step_results.delete();
    if (w.operation == OP_POP) begin
      if (held_count == 0) begin
        st = ST_EMPTY;
        step_results.push_back(r);
      end else begin
        len = 32'(ring_lengths[rd_ptr % RING_DEPTH]);
        if (len == 0) len = 1;
        if (len > MAX_REC) len = MAX_REC;
        for (k = 0; k < len; k++) begin
          r.pop_data       = ring_words[(rd_ptr + k) % RING_DEPTH];
          r.last_of_record = (k + 1 == len);
          step_results.push_back(r);
        end
        st = ST_WORD_OUT;
        release_oldest(cap);
      end
    end else begin
      if (w.first_word) begin
        words_due = 0;
        open_len  = 0;
        len       = 32'(w.record_words);
        if (len < MIN_RECORD_WORDS || len > MAX_REC || len > cap) begin
          st = ST_REJECT;
        end else begin
          // Wrap past the end with a filler, then evict until the record fits.
          fits = 1'b0;
          while (!fits) begin
            if (held_count == 0) begin
              rd_ptr = 0;
              wr_ptr = 0;
              fits   = 1'b1;
            end else if (wr_ptr > rd_ptr) begin
              if (wr_ptr + len <= cap) begin
                fits = 1'b1;
              end else begin
                ring_lengths[wr_ptr % RING_DEPTH] = 8'd0;
                wr_ptr = 0;
              end
            end else if (wr_ptr + len <= rd_ptr) begin
              fits = 1'b1;
            end else begin
              release_oldest(cap);
              dropped++;
            end
          end
          open_len  = len;
          words_due = len;
        end
      end else if (words_due == 0) begin
        st = ST_REJECT;
      end
      if (st == ST_PUSH_OK) begin
        ring_words[(wr_ptr + open_len - words_due) % RING_DEPTH] = w.push_data;
        words_due--;
        if (words_due == 0) begin
          ring_lengths[wr_ptr % RING_DEPTH] = open_len[7:0];
          wr_ptr += open_len;
          if (wr_ptr >= cap) wr_ptr = 0;
          held_count++;
          open_len = 0;
        end
      end
      step_results.push_back(r);
    end
    // Fullness counts filler words as occupied.
    if (held_count == 0) begin
      pct = 0;
    end else begin
      occ = (wr_ptr > rd_ptr) ? wr_ptr - rd_ptr : cap - (rd_ptr - wr_ptr);
      if (occ > cap) occ = cap;
      pct = occ * PCT_SCALE / cap;
    end
    foreach (step_results[j]) begin
      step_results[j].status           = st;
      step_results[j].records_held     = held_count[7:0];
      step_results[j].fullness_percent = pct[6:0];
      step_results[j].dropped_records  = dropped[7:0];
    end
  endfunction

  function automatic logic [63:0] rand_payload();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one word until it is accepted, then records what it should cause.
  task automatic send_word(input in_t w, input logic typed = 1'b0, input out_t want = '0);
    int unsigned idle;
    in_word <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    ring_predict(w);
    if (typed) results_due.push_back(want);
    else foreach (step_results[k]) results_due.push_back(step_results[k]);
    // Bursts of back-to-back words separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      idle       = $urandom_range(1, 24);
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Lets the block drain every expected result and go idle.
  task automatic settle();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    settle();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg    = 32'(value);
    rd_ptr     = 0;
    wr_ptr     = 0;
    held_count = 0;
    words_due  = 0;
    open_len   = 0;
  endtask

  // Mostly whole records with random content, plus pops, cut-off records,
  // bad lengths and stray words.
  task automatic random_traffic(input int unsigned items);
    int unsigned sent, cap, top, pick, len, stop_at, k;
    sent = 0;
    cap  = eff_capacity();
    top  = (cap < MAX_REC) ? cap : MAX_REC;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send_word(cmd(OP_POP, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                      rand_payload()));
        sent++;
      end else if (pick < 88) begin
        if ($urandom_range(0, 7) == 0) len = $urandom_range(2, top);
        else len = $urandom_range(2, (top < 10) ? top : 10);
        stop_at = (pick >= 80) ? $urandom_range(1, len - 1) : len;
        // A record that would run past the item budget is left unfinished.
        if (stop_at > items - sent) stop_at = items - sent;
        for (k = 0; k < stop_at; k++) begin
          if (k > 0 && $urandom_range(0, 19) == 0) begin
            send_word(cmd(OP_POP, 1'b0, 7'd0, rand_payload()));
            sent++;
          end
          send_word(cmd(OP_PUSH, k == 0, (k == 0) ? 7'(len) : 7'($urandom_range(0, 127)),
                        rand_payload()));
          sent++;
        end
      end else if (pick < 94) begin
        case ($urandom_range(0, 2))
          0:       len = $urandom_range(0, 1);
          1:       len = $urandom_range(MAX_REC + 1, 127);
          default: len = (cap < MAX_REC) ? $urandom_range(cap + 1, MAX_REC)
                                         : $urandom_range(MAX_REC + 1, 127);
        endcase
        send_word(cmd(OP_PUSH, 1'b1, 7'(len), rand_payload()));
        sent++;
      end else begin
        send_word(cmd(OP_PUSH, 1'b0, 7'($urandom_range(0, 127)), rand_payload()));
        sent++;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      error_count++;
      $display("%0t: %s expected %h got %h", $time, what, want_v, got_v);
    end
  endtask

  // Every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_strobe) begin
      if (results_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result expected none got %h", $time, out_word);
      end else begin
        want = results_due.pop_front();
        check_field("status", 64'(want.status), 64'(out_word.status));
        check_field("pop_data", want.pop_data, out_word.pop_data);
        check_field("last_of_record", 64'(want.last_of_record),
                    64'(out_word.last_of_record));
        check_field("records_held", 64'(want.records_held),
                    64'(out_word.records_held));
        check_field("fullness_percent", 64'(want.fullness_percent),
                    64'(out_word.fullness_percent));
        check_field("dropped_records", 64'(want.dropped_records),
                    64'(out_word.dropped_records));
      end
    end
  end

  // Ends a run in which nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t script [SCRIPT_ROWS];
    int unsigned i;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_word     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;

    // Scripted opening at the reset capacity of 256 words.
    script[0]  = '{cmd(OP_POP, 1'b0, 7'd0, '0), 1'b1, reply(ST_EMPTY, 0, 0)};
    script[1]  = '{cmd(OP_PUSH, 1'b0, 7'd127, '1), 1'b1, reply(ST_REJECT, 0, 0)};
    script[2]  = '{cmd(OP_PUSH, 1'b1, 7'd0, '0), 1'b1, reply(ST_REJECT, 0, 0)};
    script[3]  = '{cmd(OP_PUSH, 1'b1, 7'd1, '1), 1'b1, reply(ST_REJECT, 0, 0)};
    script[4]  = '{cmd(OP_PUSH, 1'b1, 7'd65, '0), 1'b1, reply(ST_REJECT, 0, 0)};
    script[5]  = '{cmd(OP_PUSH, 1'b1, 7'd127, '1), 1'b1, reply(ST_REJECT, 0, 0)};
    script[6]  = '{cmd(OP_PUSH, 1'b1, 7'd2, '1), 1'b1, reply(ST_PUSH_OK, 0, 0)};
    script[7]  = '{cmd(OP_PUSH, 1'b0, 7'd0, '0), 1'b1, reply(ST_PUSH_OK, 1, 0)};
    script[8]  = '{cmd(OP_PUSH, 1'b1, 7'd3, 64'hAAAA_AAAA_AAAA_AAAA), 1'b1,
                   reply(ST_PUSH_OK, 1, 0)};
    script[9]  = '{cmd(OP_PUSH, 1'b0, 7'd0, 64'h5555_5555_5555_5555), 1'b0, '0};
    // A new first word abandons the unfinished three-word record.
    script[10] = '{cmd(OP_PUSH, 1'b1, 7'd4, 64'h0123_4567_89AB_CDEF), 1'b0, '0};
    script[11] = '{cmd(OP_PUSH, 1'b0, 7'd0, 64'hFEDC_BA98_7654_3210), 1'b0, '0};
    script[12] = '{cmd(OP_PUSH, 1'b0, 7'd0, '1), 1'b0, '0};
    script[13] = '{cmd(OP_PUSH, 1'b0, 7'd0, 64'h8000_0000_0000_0001), 1'b0, '0};
    script[14] = '{cmd(OP_PUSH, 1'b1, 7'd5, 64'h0F0F_0F0F_0F0F_0F0F), 1'b0, '0};
    // A bad length abandons the open record; the next plain word is stray.
    script[15] = '{cmd(OP_PUSH, 1'b1, 7'd1, '0), 1'b1, reply(ST_REJECT, 2, 2)};
    script[16] = '{cmd(OP_PUSH, 1'b0, 7'd3, '1), 1'b1, reply(ST_REJECT, 2, 2)};
    script[17] = '{cmd(OP_POP, 1'b0, 7'd0, '0), 1'b0, '0};
    script[18] = '{cmd(OP_POP, 1'b0, 7'd0, '0), 1'b0, '0};
    script[19] = '{cmd(OP_POP, 1'b1, 7'd127, '1), 1'b1, reply(ST_EMPTY, 0, 0)};
    script[20] = '{cmd(OP_PUSH, 1'b1, 7'd2, '0), 1'b1, reply(ST_PUSH_OK, 0, 0)};
    script[21] = '{cmd(OP_PUSH, 1'b0, 7'd0, '1), 1'b1, reply(ST_PUSH_OK, 1, 0)};
    script[22] = '{cmd(OP_POP, 1'b0, 7'd0, '0), 1'b0, '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < SCRIPT_ROWS; i++)
      send_word(script[i].word, script[i].typed, script[i].want);

    // Random traffic at several capacities, clamped values included.
    write_capacity(9'd8);
    random_traffic(25);
    write_capacity(9'd3);
    random_traffic(12);
    write_capacity(9'd24);
    random_traffic(30);
    write_capacity(9'd64);
    random_traffic(30);
    write_capacity(9'd511);
    random_traffic(35);
    write_capacity(9'd100);
    random_traffic(15);
    write_capacity(9'd256);
    random_traffic(10);

    settle();
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
